>>> rtl/wsrm_pkg.sv
// Package for the wildcard string rule matcher: shared constants, register
// and mode codes, the configuration and word structs, and the helper functions.
// No dependencies.
`default_nettype none

package wsrm_pkg;

    // Sizes
    localparam int PATTERN_MAX_DEF = 32;
    localparam int PATTERN_LIMIT   = 32;
    localparam int SET_W           = PATTERN_LIMIT + 1;
    localparam int CLOSURE_LEVELS  = $clog2(SET_W);
    localparam int CHAR_W          = 8;
    localparam int CHARS_PER_WORD  = 8;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_IDX_W       = 3;
    localparam int MODE_W          = 3;
    localparam int LEN_W           = 6;
    localparam int NULL_LEN        = 4;

    // Special characters
    localparam logic [CHAR_W-1:0] CHAR_STAR    = 8'h2A;
    localparam logic [CHAR_W-1:0] CHAR_QUEST   = 8'h3F;
    localparam logic [CHAR_W-1:0] CHAR_GT      = 8'h3E;
    localparam logic [CHAR_W-1:0] CHAR_BSLASH  = 8'h5C;
    localparam logic [CHAR_W-1:0] CHAR_SLASH   = 8'h2F;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'h20;

    // The word "NULL", first character in the top byte.
    localparam logic [NULL_LEN*CHAR_W-1:0] NULL_WORD = 32'h4E55_4C4C;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_A      = 3'd2;

    // Rule modes
    localparam logic [MODE_W-1:0] MODE_EQUAL           = 3'd0;
    localparam logic [MODE_W-1:0] MODE_NOT_EQUAL       = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MATCH_NOCASE    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_NOTMATCH_NOCASE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_MATCH_CASE      = 3'd4;
    localparam logic [MODE_W-1:0] MODE_NOTMATCH_CASE   = 3'd5;

    // Rule settings handed from the register file to the match core.
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [LEN_W-1:0]  length;
    } cfg_t;

    // One input word as held in the input register.
    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              is_last;
        logic              string_empty;
    } item_t;

    // ASCII upper-case folding; other codes pass unchanged.
    function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] c);
        return (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) ? c - CASE_OFFSET : c;
    endfunction

    // Star closure as a parallel prefix: a position becomes active when an
    // active position below it reaches it through positions whose propagate
    // bit is set. prop[j] allows a move from j-1 into j.
    function automatic logic [SET_W-1:0] closure(input logic [SET_W-1:0] seed,
                                                 input logic [SET_W-1:0] prop);
        logic [SET_W-1:0] g;
        logic [SET_W-1:0] p;
        g = seed;
        p = prop;
        for (int k = 0; k < CLOSURE_LEVELS; k++) begin
            g = g | (p & (g << (1 << k)));
            p = p & (p << (1 << k));
        end
        return g;
    endfunction

endpackage

`default_nettype wire

>>> rtl/wsrm_cfg.sv
// Configuration register file of the wildcard string rule matcher: rule mode,
// pattern length and the pattern characters. Depends on wsrm_pkg.
`default_nettype none

module wsrm_cfg #(
    parameter int PATTERN_MAX = wsrm_pkg::PATTERN_MAX_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [wsrm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [wsrm_pkg::CFG_DATA_W-1:0]       cfg_data,
    output wsrm_pkg::cfg_t                             cfg_o,
    output logic [PATTERN_MAX*wsrm_pkg::CHAR_W-1:0]    pattern_o
);

    localparam int CW = wsrm_pkg::CHAR_W;
    localparam int IW = wsrm_pkg::CFG_IDX_W;

    logic [wsrm_pkg::MODE_W-1:0]  mode_reg;
    logic [wsrm_pkg::LEN_W-1:0]   length_reg;
    logic [PATTERN_MAX*CW-1:0]    pattern_reg;

    // Register writes; each pattern word covers eight characters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= wsrm_pkg::MODE_MATCH_NOCASE;
            length_reg  <= '0;
            pattern_reg <= '0;
        end else if (cfg_wr_en) begin
            if (cfg_index == wsrm_pkg::REG_MATCH_MODE) begin
                mode_reg <= cfg_data[wsrm_pkg::MODE_W-1:0];
            end
            if (cfg_index == wsrm_pkg::REG_PATTERN_LENGTH) begin
                length_reg <= cfg_data[wsrm_pkg::LEN_W-1:0];
            end
            for (int j = 0; j < PATTERN_MAX; j++) begin
                if (cfg_index == IW'(int'(wsrm_pkg::REG_PATTERN_A)
                                     + j / wsrm_pkg::CHARS_PER_WORD)) begin
                    pattern_reg[j*CW +: CW] <=
                        cfg_data[(j % wsrm_pkg::CHARS_PER_WORD)*CW +: CW];
                end
            end
        end
    end

    assign cfg_o.mode   = mode_reg;
    assign cfg_o.length = length_reg;
    assign pattern_o    = pattern_reg;

endmodule

`default_nettype wire

>>> rtl/wsrm_core.sv
// Match core of the wildcard string rule matcher: the per-string state and
// the one-word update and verdict logic. Depends on wsrm_pkg.
`default_nettype none

module wsrm_core #(
    parameter int PATTERN_MAX = wsrm_pkg::PATTERN_MAX_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  item_fire,
    input  wire wsrm_pkg::item_t                       item,
    input  wire wsrm_pkg::cfg_t                        cfg,
    input  wire logic [PATTERN_MAX*wsrm_pkg::CHAR_W-1:0] pattern,
    output logic                                       ends_o,
    output logic                                       matched_o
);

    localparam int CW = wsrm_pkg::CHAR_W;
    localparam int LW = wsrm_pkg::LEN_W;
    localparam int SW = wsrm_pkg::SET_W;
    localparam int AW = PATTERN_MAX + 1;
    localparam logic [LW-1:0] CNT_SAT = '1;

    // Per-string state
    logic [AW-1:0] act_reg;
    logic          sep_reg;
    logic [LW-1:0] cnt_reg;
    logic          fail_reg;

    logic [LW-1:0]          len;
    logic                   nocase;
    logic [CW-1:0]          c_fold;
    logic [PATTERN_MAX-1:0] in_use;
    logic [PATTERN_MAX-1:0] star_raw;
    logic [PATTERN_MAX-1:0] gt_raw;
    logic [PATTERN_MAX-1:0] star_mask;
    logic [PATTERN_MAX-1:0] star_gt_mask;
    logic [PATTERN_MAX-1:0] hit;
    logic [PATTERN_MAX-1:0] last_pos;
    logic [PATTERN_MAX-1:0] prev_pos;
    logic [PATTERN_MAX-1:0] cnt_sel;
    logic [PATTERN_MAX-1:0] exact_eq;
    logic                   trig;
    logic [SW-1:0]          act_closed;
    logic [AW-1:0]          a;
    logic [AW-1:0]          act_new;
    logic                   sep_hit;
    logic                   fail_now;
    logic [LW-1:0]          cnt_inc;
    logic [AW-1:0]          act_post;
    logic                   sep_post;
    logic [LW-1:0]          cnt_post;
    logic                   fail_post;
    logic [SW-1:0]          acc_set;
    logic                   glob;
    logic                   eq;
    logic                   null_chars_ok;
    logic                   null_case;
    logic                   verdict;

    // Pattern length in use and case mode.
    assign len = (cfg.length > LW'(PATTERN_MAX)) ? LW'(PATTERN_MAX) : cfg.length;
    assign nocase = (cfg.mode == wsrm_pkg::MODE_MATCH_NOCASE) ||
                    (cfg.mode == wsrm_pkg::MODE_NOTMATCH_NOCASE);
    assign c_fold = wsrm_pkg::fold(item.char_code);

    // Per-position decode of the pattern against the current character.
    always_comb begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
            in_use[i]       = LW'(i) < len;
            star_raw[i]     = pattern[i*CW +: CW] == wsrm_pkg::CHAR_STAR;
            gt_raw[i]       = pattern[i*CW +: CW] == wsrm_pkg::CHAR_GT;
            star_mask[i]    = in_use[i] && star_raw[i];
            star_gt_mask[i] = in_use[i] && (star_raw[i] || gt_raw[i]);
            exact_eq[i]     = pattern[i*CW +: CW] == item.char_code;
            hit[i]          = (pattern[i*CW +: CW] == wsrm_pkg::CHAR_QUEST) ||
                              (nocase ? (wsrm_pkg::fold(pattern[i*CW +: CW]) == c_fold)
                                      : exact_eq[i]);
            last_pos[i]     = len == LW'(i + 1);
            prev_pos[i]     = len == LW'(i + 2);
            cnt_sel[i]      = cnt_reg == LW'(i);
        end
    end

    // A final '>' not after a star acts as the separator rule.
    assign trig = (len >= LW'(2)) && (|(last_pos & gt_raw)) && !(|(prev_pos & star_raw));

    // Close the active set over stars, then step it by one character.
    assign act_closed = wsrm_pkg::closure(SW'(act_reg), SW'({star_mask, 1'b0}));
    assign a          = act_closed[AW-1:0];

    always_comb begin
        act_new = '0;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            act_new[i]     = act_new[i] | (a[i] && star_mask[i]);
            act_new[i + 1] = act_new[i + 1] | (a[i] && in_use[i] && !star_raw[i] &&
                             !(trig && last_pos[i]) && hit[i]);
        end
    end

    assign sep_hit = trig && (|(a[PATTERN_MAX-1:0] & last_pos)) &&
                     ((item.char_code == wsrm_pkg::CHAR_SLASH) ||
                      (item.char_code == wsrm_pkg::CHAR_BSLASH));

    // Exact-equality tracking with a saturating character count.
    assign fail_now = (cnt_reg >= len) || !(|(cnt_sel & exact_eq));
    assign cnt_inc  = (cnt_reg == CNT_SAT) ? cnt_reg : cnt_reg + LW'(1);

    // State after this word; an empty mark adds no character.
    assign act_post  = item.string_empty ? act_reg  : act_new;
    assign sep_post  = item.string_empty ? sep_reg  : (sep_reg || sep_hit);
    assign cnt_post  = item.string_empty ? cnt_reg  : cnt_inc;
    assign fail_post = item.string_empty ? fail_reg : (fail_reg || fail_now);
    assign ends_o    = item.string_empty || item.is_last;

    // Acceptance: the end is reachable through trailing stars and marks.
    assign acc_set = wsrm_pkg::closure(SW'(act_post), SW'({star_gt_mask, 1'b0}));
    assign glob    = sep_post || acc_set[len];
    assign eq      = !fail_post && (cnt_post == len);

    // Empty string against the pattern "NULL".
    always_comb begin
        null_chars_ok = 1'b1;
        for (int i = 0; i < wsrm_pkg::NULL_LEN && i < PATTERN_MAX; i++) begin
            null_chars_ok = null_chars_ok && (pattern[i*CW +: CW] ==
                            wsrm_pkg::NULL_WORD[(wsrm_pkg::NULL_LEN-1-i)*CW +: CW]);
        end
    end
    assign null_case = (cnt_post == '0) && (len == LW'(wsrm_pkg::NULL_LEN)) && null_chars_ok;

    // Verdict by rule mode.
    always_comb begin
        if (null_case) begin
            verdict = (cfg.mode == wsrm_pkg::MODE_EQUAL) ||
                      (cfg.mode == wsrm_pkg::MODE_MATCH_NOCASE) ||
                      (cfg.mode == wsrm_pkg::MODE_MATCH_CASE);
        end else begin
            unique case (cfg.mode)
                wsrm_pkg::MODE_EQUAL:           verdict = eq;
                wsrm_pkg::MODE_NOT_EQUAL:       verdict = !eq;
                wsrm_pkg::MODE_MATCH_NOCASE:    verdict = glob;
                wsrm_pkg::MODE_MATCH_CASE:      verdict = glob;
                wsrm_pkg::MODE_NOTMATCH_NOCASE: verdict = !glob;
                wsrm_pkg::MODE_NOTMATCH_CASE:   verdict = !glob;
                default:                        verdict = 1'b0;
            endcase
        end
    end
    assign matched_o = verdict;

    // State update; a finished string returns to the start set.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg  <= AW'(1);
            sep_reg  <= 1'b0;
            cnt_reg  <= '0;
            fail_reg <= 1'b0;
        end else if (item_fire) begin
            if (ends_o) begin
                act_reg  <= AW'(1);
                sep_reg  <= 1'b0;
                cnt_reg  <= '0;
                fail_reg <= 1'b0;
            end else begin
                act_reg  <= act_post;
                sep_reg  <= sep_post;
                cnt_reg  <= cnt_post;
                fail_reg <= fail_post;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/wildcard_string_rule_matcher.sv
// Top level of the wildcard string rule matcher: input register, output
// register and handshake. Depends on wsrm_pkg, wsrm_cfg and wsrm_core.
//
//   Channel   Direction  Handshake            Payload
//   s_        in         s_valid / s_ready    s_char_code, s_is_last, s_string_empty
//   m_        out        m_valid / m_ready    m_matched
//   cfg_      in         cfg_wr_en            cfg_index, cfg_data
//
// One word is taken every cycle unless a held result stalls it; the verdict for
// a word that ends its string passes the input register, then the result register.
// The active-position set is closed and stepped combinationally for each character.
// Reset (aresetn low, synchronous) empties both registers, loads the register
// defaults and returns the match state to the start set.
// A held result stalls only words that end a string; other words keep flowing.
`default_nettype none

module wildcard_string_rule_matcher #(
    parameter int PATTERN_MAX = wsrm_pkg::PATTERN_MAX_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [wsrm_pkg::CHAR_W-1:0]      s_char_code,
    input  wire logic                             s_is_last,
    input  wire logic                             s_string_empty,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic                                  m_matched,
    input  wire logic                             cfg_wr_en,
    input  wire logic [wsrm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [wsrm_pkg::CFG_DATA_W-1:0]  cfg_data
);

    wsrm_pkg::cfg_t                        cfg;
    logic [PATTERN_MAX*wsrm_pkg::CHAR_W-1:0] pattern;
    wsrm_pkg::item_t                       item_reg;
    logic                                  in_valid_reg;
    logic                                  out_valid_reg;
    logic                                  matched_reg;
    logic                                  ends;
    logic                                  verdict;
    logic                                  adv;

    wsrm_cfg #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_o     (cfg),
        .pattern_o (pattern)
    );

    wsrm_core #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item_fire (adv),
        .item      (item_reg),
        .cfg       (cfg),
        .pattern   (pattern),
        .ends_o    (ends),
        .matched_o (verdict)
    );

    // The held word moves on unless it needs the result register and that is full.
    assign adv     = in_valid_reg && (!ends || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || adv;

    // Handshake control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (adv && ends) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.char_code    <= s_char_code;
            item_reg.is_last      <= s_is_last;
            item_reg.string_empty <= s_string_empty;
        end
        if (adv && ends) begin
            matched_reg <= verdict;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_matched = matched_reg;

endmodule

`default_nettype wire

>>> rtl/wsrm_checker.sv
// Port-level checker for the wildcard string rule matcher and its bind.
// Depends on wsrm_pkg and wildcard_string_rule_matcher.
`default_nettype none

module wsrm_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_valid,
    input wire logic                            s_ready,
    input wire logic [wsrm_pkg::CHAR_W-1:0]     s_char_code,
    input wire logic                            m_valid,
    input wire logic                            m_ready,
    input wire logic                            m_matched
);

    // A stalled result holds its verdict.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_matched))
        else $error("result word changed while stalled");

    // Reset leaves no result pending.
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // With the result register empty the input side never stalls.
    a_no_false_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with no result pending");

    // An accepted character word carries known data.
    a_char_known: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |-> !$isunknown(s_char_code))
        else $error("unknown character accepted");

endmodule

bind wildcard_string_rule_matcher wsrm_checker u_wsrm_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_char_code (s_char_code),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_matched   (m_matched)
);

`default_nettype wire
